// ----- hw/rtl/eps_pkg.sv -----
// Package for the encoder period, speed and odometer unit.
// Holds the shared widths, register indexes and channel count; no dependencies.

package eps_pkg;

  // Number of wheel channels that keep state.
  localparam int NUM_CHANNELS = 2;

  // Field widths fixed by the item formats.
  localparam int CH_W      = 1;
  localparam int TIME_W    = 32;
  localparam int DIR_W     = 2;
  localparam int DIST_W    = 48;
  localparam int MINP_W    = 16;
  localparam int STEP_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Divider iteration counter, one quotient bit per cycle.
  localparam int DIV_CNT_W = $clog2(TIME_W);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PERIOD    = 2'd0,
    REG_VEL_NUMERATOR = 2'd1,
    REG_RPM_NUMERATOR = 2'd2,
    REG_DIST_STEP     = 2'd3
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [MINP_W-1:0] MIN_PERIOD_RST    = 16'd100;
  localparam logic [TIME_W-1:0] VEL_NUMERATOR_RST = 32'd2613806;
  localparam logic [TIME_W-1:0] RPM_NUMERATOR_RST = 32'd768000000;
  localparam logic [STEP_W-1:0] DIST_STEP_RST     = 20'd0;

  // Velocity saturation limits.
  localparam logic [TIME_W-1:0] VEL_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] VEL_NEG_MAG = 32'h8000_0000;

endpackage

// ----- hw/rtl/eps_evt_if.sv -----
// Item channel interfaces for the encoder period, speed and odometer unit.
// Depends on eps_pkg for the field widths.

interface eps_evt_if;
  logic                                  valid;
  logic                                  ready;
  logic [eps_pkg::CH_W-1:0]              channel_select;
  logic [eps_pkg::TIME_W-1:0]            capture_time;
  logic signed [eps_pkg::DIR_W-1:0]      direction;
  logic [eps_pkg::TIME_W-1:0]            ms_time;

  modport source (output valid, channel_select, capture_time, direction, ms_time,
                  input ready);
  modport sink (input valid, channel_select, capture_time, direction, ms_time,
                output ready);
endinterface

interface eps_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [eps_pkg::CH_W-1:0]              out_channel;
  logic [eps_pkg::TIME_W-1:0]            period_out;
  logic signed [eps_pkg::TIME_W-1:0]     velocity_out;
  logic [eps_pkg::TIME_W-1:0]            rpm_out;
  logic signed [eps_pkg::DIST_W-1:0]     distance_out;
  logic [eps_pkg::TIME_W-1:0]            edge_count;
  logic                                  active_flag;
  logic [eps_pkg::TIME_W-1:0]            last_time;

  modport source (output valid, out_channel, period_out, velocity_out, rpm_out,
                  distance_out, edge_count, active_flag, last_time,
                  input ready);
  modport sink (input valid, out_channel, period_out, velocity_out, rpm_out,
                distance_out, edge_count, active_flag, last_time,
                output ready);
endinterface

// ----- hw/rtl/encoder_period_speed_odometer_unit.sv -----
// Encoder period, speed and odometer unit: per-channel state, sequencer and
// a shared restoring divider. Depends on eps_pkg and the eps_evt_if/eps_res_if
// interfaces.
//
// Usage: each item on evt is one encoder capture event (channel, capture
// timer value, direction, millisecond time). For every item exactly one item
// leaves on res with that channel's updated period, velocity, rpm, distance,
// edge count, active flag and last event time.
// The sequencer takes one item at a time; evt.ready is high only while it is
// idle. An item whose period is above min_period runs two 32-step divisions
// (velocity, then rpm) through one shared subtract-and-shift unit, one
// quotient bit per cycle, then commits; its result is loaded in the final
// step, and the next item is taken once idle again. An item with a short
// period or an unused channel skips the divisions and goes to the final step.
// A finished result sits in the output register until res.ready; the unit
// meanwhile goes back to idle and accepts the next item, which then waits at
// its last step until the output register is free.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are meant for idle periods. Synchronous reset restores the register
// defaults, clears all channel state and empties the output register.

module encoder_period_speed_odometer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eps_pkg::CFG_DAT_W-1:0]      cfg_data,
  eps_evt_if.sink                            evt,
  eps_res_if.source                          res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_VEL,
    S_DIV_RPM,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [eps_pkg::MINP_W-1:0] min_period;
  logic [eps_pkg::TIME_W-1:0] vel_numerator;
  logic [eps_pkg::TIME_W-1:0] rpm_numerator;
  logic [eps_pkg::STEP_W-1:0] dist_step;

  // Per-channel state.
  logic [eps_pkg::TIME_W-1:0]        last_capture [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::TIME_W-1:0]        edge_total   [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::TIME_W-1:0]        edge_time    [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::TIME_W-1:0]        period_reg   [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::TIME_W-1:0]        velocity_reg [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::TIME_W-1:0]        rpm_reg      [eps_pkg::NUM_CHANNELS];
  logic signed [eps_pkg::DIST_W-1:0] distance_reg [eps_pkg::NUM_CHANNELS];
  logic [eps_pkg::NUM_CHANNELS-1:0]  active_reg;

  // Latched item.
  logic [eps_pkg::CH_W-1:0]   ch;
  logic [eps_pkg::TIME_W-1:0] cap;
  logic [eps_pkg::DIR_W-1:0]  dir;
  logic [eps_pkg::TIME_W-1:0] ms;

  // Working registers.
  logic [eps_pkg::TIME_W-1:0]    per;
  logic [eps_pkg::TIME_W-1:0]    vel_quo;
  logic [eps_pkg::TIME_W-1:0]    rem;
  logic [eps_pkg::TIME_W-1:0]    quo;
  logic [eps_pkg::DIV_CNT_W-1:0] cnt;

  logic                          evt_fire;
  logic                          res_free;
  logic                          ch_ok;
  logic                          dir_neg;
  logic                          dir_pos;
  logic [eps_pkg::TIME_W-1:0]    per_new;
  logic [eps_pkg::TIME_W:0]      trial;
  logic [eps_pkg::TIME_W+1:0]    diff;
  logic [eps_pkg::TIME_W-1:0]    rem_next;
  logic [eps_pkg::TIME_W-1:0]    quo_next;
  logic [eps_pkg::TIME_W-1:0]    vel_sat;
  logic signed [eps_pkg::DIST_W-1:0] step_ext;

  assign evt.ready = (state == S_IDLE);
  assign evt_fire  = evt.valid && evt.ready;
  assign res_free  = !res.valid || res.ready;

  // Channel range and direction decode of the latched item.
  assign ch_ok   = ({{(32-eps_pkg::CH_W){1'b0}}, ch} < 32'(eps_pkg::NUM_CHANNELS));
  assign dir_neg = dir[eps_pkg::DIR_W-1];
  assign dir_pos = (dir == 2'b01);
  assign per_new = cap - last_capture[ch];
  assign step_ext = signed'({{(eps_pkg::DIST_W-eps_pkg::STEP_W){1'b0}}, dist_step});

  // One restoring division step: shift in the next dividend bit, try to subtract.
  always_comb begin
    trial = {rem, quo[eps_pkg::TIME_W-1]};
    diff  = {1'b0, trial} - {2'b00, per};
    if (!diff[eps_pkg::TIME_W+1]) begin
      rem_next = diff[eps_pkg::TIME_W-1:0];
      quo_next = {quo[eps_pkg::TIME_W-2:0], 1'b1};
    end else begin
      rem_next = trial[eps_pkg::TIME_W-1:0];
      quo_next = {quo[eps_pkg::TIME_W-2:0], 1'b0};
    end
  end

  // Signed velocity from the unsigned quotient, saturated by direction.
  always_comb begin
    if (dir_neg) begin
      vel_sat = (vel_quo > eps_pkg::VEL_NEG_MAG) ? (32'd0 - eps_pkg::VEL_NEG_MAG)
                                                 : (32'd0 - vel_quo);
    end else begin
      vel_sat = (vel_quo > eps_pkg::VEL_POS_MAX) ? eps_pkg::VEL_POS_MAX : vel_quo;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period    <= eps_pkg::MIN_PERIOD_RST;
      vel_numerator <= eps_pkg::VEL_NUMERATOR_RST;
      rpm_numerator <= eps_pkg::RPM_NUMERATOR_RST;
      dist_step     <= eps_pkg::DIST_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        eps_pkg::REG_MIN_PERIOD:    min_period    <= cfg_data[eps_pkg::MINP_W-1:0];
        eps_pkg::REG_VEL_NUMERATOR: vel_numerator <= cfg_data;
        eps_pkg::REG_RPM_NUMERATOR: rpm_numerator <= cfg_data;
        eps_pkg::REG_DIST_STEP:     dist_step     <= cfg_data[eps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, channel state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res.valid  <= 1'b0;
      active_reg <= '0;
      for (int i = 0; i < eps_pkg::NUM_CHANNELS; i++) begin
        last_capture[i] <= '0;
        edge_total[i]   <= '0;
        edge_time[i]    <= '0;
        period_reg[i]   <= '0;
        velocity_reg[i] <= '0;
        rpm_reg[i]      <= '0;
        distance_reg[i] <= '0;
      end
    end else begin
      // The final step reloads the output register itself.
      if (res.valid && res.ready && state != S_DONE) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (evt_fire) begin
            ch    <= evt.channel_select;
            cap   <= evt.capture_time;
            dir   <= evt.direction;
            ms    <= evt.ms_time;
            state <= S_PREP;
          end
        end
        // Period, bookkeeping and distance; start the velocity division if needed.
        S_PREP: begin
          if (!ch_ok) begin
            state <= S_DONE;
          end else begin
            per              <= per_new;
            last_capture[ch] <= cap;
            edge_time[ch]    <= ms;
            edge_total[ch]   <= edge_total[ch] + 32'd1;
            if (dir_neg) begin
              distance_reg[ch] <= distance_reg[ch] - step_ext;
            end else if (dir_pos) begin
              distance_reg[ch] <= distance_reg[ch] + step_ext;
            end
            if (per_new > {16'd0, min_period}) begin
              rem   <= '0;
              quo   <= vel_numerator;
              cnt   <= '1;
              state <= S_DIV_VEL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // Velocity quotient; the last step reloads the divider for rpm.
        S_DIV_VEL: begin
          if (cnt == '0) begin
            vel_quo <= quo_next;
            rem     <= '0;
            quo     <= rpm_numerator;
            cnt     <= '1;
            state   <= S_DIV_RPM;
          end else begin
            rem <= rem_next;
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_RPM: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_COMMIT;
          end
        end
        // Store the new speeds; velocity holds when the motor is stopped.
        S_COMMIT: begin
          period_reg[ch] <= per;
          rpm_reg[ch]    <= quo;
          active_reg[ch] <= 1'b1;
          if (dir_neg || dir_pos) begin
            velocity_reg[ch] <= vel_sat;
          end
          state <= S_DONE;
        end
        // Hand the channel's values to the output register once it is free.
        S_DONE: begin
          if (res_free) begin
            res.valid       <= 1'b1;
            res.out_channel <= ch;
            if (ch_ok) begin
              res.period_out   <= period_reg[ch];
              res.velocity_out <= signed'(velocity_reg[ch]);
              res.rpm_out      <= rpm_reg[ch];
              res.distance_out <= distance_reg[ch];
              res.edge_count   <= edge_total[ch];
              res.active_flag  <= active_reg[ch];
              res.last_time    <= edge_time[ch];
            end else begin
              res.period_out   <= '0;
              res.velocity_out <= '0;
              res.rpm_out      <= '0;
              res.distance_out <= '0;
              res.edge_count   <= '0;
              res.active_flag  <= 1'b0;
              res.last_time    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // An accepted item always goes to the period step next.
  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    evt_fire |=> state == S_PREP)
    else $error("accepted item did not enter the period step");

  // A new result appears only from the final step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the final step");

  // The division remainder stays below the divisor.
  a_rem_below_per: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_VEL || state == S_DIV_RPM) |-> rem < per)
    else $error("divider remainder reached the divisor");

  // The edge count of a used channel advances by exactly one per item.
  a_edge_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP && ch_ok) |=> edge_total[ch] == $past(edge_total[ch]) + 32'd1)
    else $error("edge count did not advance by one");

  // The output register is never overwritten while its item waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready && state == S_DONE) |=> state == S_DONE)
    else $error("pending result overwritten");
`endif

endmodule

// ----- tb/eps_odometer_checker.sv -----
`timescale 1ns / 100ps
// Checker for the encoder period, speed and odometer unit: it mirrors the configuration port,
// predicts each wheel update from the accepted capture events and compares the result items.
// Depends on eps_pkg and the eps_evt_if / eps_res_if interfaces.

module eps_odometer_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eps_pkg::CFG_DAT_W-1:0] cfg_data,
  eps_evt_if                            evt,
  eps_res_if                            res,
  output int                            mismatches,
  output int                            updates_due
);
  import eps_pkg::*;

  // One expected result item: the channel's values after the event.
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic [TIME_W-1:0]        period;
    logic signed [TIME_W-1:0] velocity;
    logic [TIME_W-1:0]        rpm;
    logic signed [DIST_W-1:0] distance;
    logic [TIME_W-1:0]        edges;
    logic                     active;
    logic [TIME_W-1:0]        last_ms;
  } wheel_update_t;

  // Mirrored configuration.
  logic [MINP_W-1:0] min_period;
  logic [TIME_W-1:0] vel_numerator;
  logic [TIME_W-1:0] rpm_numerator;
  logic [STEP_W-1:0] dist_step;

  // Mirrored per-channel state.
  logic [TIME_W-1:0] capture_seen [NUM_CHANNELS];
  logic [TIME_W-1:0] edge_tally   [NUM_CHANNELS];
  logic [TIME_W-1:0] event_ms     [NUM_CHANNELS];
  logic [TIME_W-1:0] period_kept  [NUM_CHANNELS];
  logic [TIME_W-1:0] velocity_kept[NUM_CHANNELS];
  logic [TIME_W-1:0] rpm_kept     [NUM_CHANNELS];
  logic [DIST_W-1:0] travel       [NUM_CHANNELS];
  logic              measured     [NUM_CHANNELS];

  wheel_update_t wheel_updates_pending[$];
  wheel_update_t next_due;

  initial mismatches = 0;

  // Applies one capture event to the mirrored state and returns the channel's new values.
  function automatic wheel_update_t predict_wheel_update(
    input logic [CH_W-1:0]          ch,
    input logic [TIME_W-1:0]        cap,
    input logic signed [DIR_W-1:0]  dir,
    input logic [TIME_W-1:0]        ms
  );
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W-1:0] magnitude;
    wheel_update_t     upd;
    upd = '0;
    upd.channel = ch;
    if (ch >= NUM_CHANNELS) return upd;

    period = cap - capture_seen[ch];
    capture_seen[ch] = cap;
    event_ms[ch] = ms;
    edge_tally[ch] = edge_tally[ch] + 1'b1;

    // Short periods count as glitches and leave the speeds alone.
    if (period > min_period) begin
      quotient = vel_numerator / period;
      period_kept[ch] = period;
      if (dir < 0) begin
        magnitude = (quotient > VEL_NEG_MAG) ? VEL_NEG_MAG : quotient;
        velocity_kept[ch] = '0 - magnitude;
      end else if (dir > 0) begin
        velocity_kept[ch] = (quotient > VEL_POS_MAX) ? VEL_POS_MAX : quotient;
      end
      rpm_kept[ch] = rpm_numerator / period;
      measured[ch] = 1'b1;
    end

    // Travel follows the direction; a stopped motor adds nothing.
    if (dir < 0) travel[ch] = travel[ch] - DIST_W'(dist_step);
    else if (dir > 0) travel[ch] = travel[ch] + DIST_W'(dist_step);

    upd.period   = period_kept[ch];
    upd.velocity = velocity_kept[ch];
    upd.rpm      = rpm_kept[ch];
    upd.distance = travel[ch];
    upd.edges    = edge_tally[ch];
    upd.active   = measured[ch];
    upd.last_ms  = event_ms[ch];
    return upd;
  endfunction

  task automatic check_field(input string name, input logic [DIST_W-1:0] expected,
                             input logic [DIST_W-1:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
      mismatches++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (rst) begin
      min_period    = MIN_PERIOD_RST;
      vel_numerator = VEL_NUMERATOR_RST;
      rpm_numerator = RPM_NUMERATOR_RST;
      dist_step     = DIST_STEP_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        capture_seen[i]  = '0;
        edge_tally[i]    = '0;
        event_ms[i]      = '0;
        period_kept[i]   = '0;
        velocity_kept[i] = '0;
        rpm_kept[i]      = '0;
        travel[i]        = '0;
        measured[i]      = 1'b0;
      end
      wheel_updates_pending.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_PERIOD:    min_period    = cfg_data[MINP_W-1:0];
          REG_VEL_NUMERATOR: vel_numerator = cfg_data[TIME_W-1:0];
          REG_RPM_NUMERATOR: rpm_numerator = cfg_data[TIME_W-1:0];
          REG_DIST_STEP:     dist_step     = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      // Compare a finished result item with the oldest prediction.
      if (res.valid && res.ready) begin
        if (wheel_updates_pending.size() == 0) begin
          $error("result item for channel %0d arrived with no update pending",
                 res.out_channel);
          mismatches++;
        end else begin
          next_due = wheel_updates_pending.pop_front();
          check_field("out_channel", DIST_W'(next_due.channel), DIST_W'(res.out_channel));
          check_field("period_out", DIST_W'(next_due.period), DIST_W'(res.period_out));
          check_field("velocity_out", DIST_W'(next_due.velocity),
                      DIST_W'(res.velocity_out));
          check_field("rpm_out", DIST_W'(next_due.rpm), DIST_W'(res.rpm_out));
          check_field("distance_out", next_due.distance, res.distance_out);
          check_field("edge_count", DIST_W'(next_due.edges), DIST_W'(res.edge_count));
          check_field("active_flag", DIST_W'(next_due.active), DIST_W'(res.active_flag));
          check_field("last_time", DIST_W'(next_due.last_ms), DIST_W'(res.last_time));
        end
      end

      if (evt.valid && evt.ready) begin
        wheel_updates_pending.push_back(predict_wheel_update(
          evt.channel_select, evt.capture_time, evt.direction, evt.ms_time));
      end
    end
    updates_due = wheel_updates_pending.size();
  end

endmodule

// ----- tb/encoder_period_speed_odometer_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the encoder period, speed and odometer unit test: clock, reset, capture events,
// configuration phases, result back-pressure and the verdict.
// Depends on eps_pkg, the channel interfaces, the unit and eps_odometer_checker.

module encoder_period_speed_odometer_unit_test;
  import eps_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int MODE_SPAN       = 25;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 100;

  // Direction codes; the two-bit pattern for -2 is treated as reverse.
  localparam logic signed [DIR_W-1:0] DIR_STOP    = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_FWD     = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REV     = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_REV_ALT = 2'sb10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  eps_evt_if evt_ch ();
  eps_res_if res_ch ();

  int mismatches;
  int updates_due;
  int src_idle_pct;
  int sink_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic evt_taken = 1'b0;

  // Stimulus-side copy of the last capture time per channel and the current threshold.
  logic [TIME_W-1:0] wheel_capture [NUM_CHANNELS];
  logic [MINP_W-1:0] min_period_now;

  encoder_period_speed_odometer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .res       (res_ch)
  );

  eps_odometer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .evt         (evt_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .updates_due (updates_due)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Remembers whether the last rising edge took an event item.
  always @(posedge clk) begin
    evt_taken <= evt_ch.valid && evt_ch.ready;
  end

  // Result receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      res_ch.ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_served <= hold_requests;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL encoder_period_speed_odometer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one capture event a given number of ticks after the channel's last one.
  task automatic send_capture(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] gap,
                              input logic signed [DIR_W-1:0] dir,
                              input logic [TIME_W-1:0] ms);
    wheel_capture[ch] = wheel_capture[ch] + gap;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid          <= 1'b1;
    evt_ch.channel_select <= ch;
    evt_ch.capture_time   <= wheel_capture[ch];
    evt_ch.direction      <= dir;
    evt_ch.ms_time        <= ms;
    do @(negedge clk); while (!evt_taken);
  endtask

  // Stops offering and waits until every predicted update has come back.
  task automatic settle();
    evt_ch.valid <= 1'b0;
    while (updates_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers on consecutive cycles; the unit must be idle.
  task automatic configure(input logic [MINP_W-1:0] minp, input logic [TIME_W-1:0] vel,
                           input logic [TIME_W-1:0] rpm, input logic [STEP_W-1:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_PERIOD;
    cfg_data  <= CFG_DAT_W'(minp);
    @(negedge clk);
    cfg_index <= REG_VEL_NUMERATOR;
    cfg_data  <= vel;
    @(negedge clk);
    cfg_index <= REG_RPM_NUMERATOR;
    cfg_data  <= rpm;
    @(negedge clk);
    cfg_index <= REG_DIST_STEP;
    cfg_data  <= CFG_DAT_W'(step);
    @(negedge clk);
    cfg_we <= 1'b0;
    min_period_now = minp;
  endtask

  initial begin
    logic [CH_W-1:0]         ch;
    logic [TIME_W-1:0]       gap;
    logic signed [DIR_W-1:0] dir;
    int                      pick;

    evt_ch.valid          = 1'b0;
    evt_ch.channel_select = '0;
    evt_ch.capture_time   = '0;
    evt_ch.direction      = DIR_STOP;
    evt_ch.ms_time        = '0;
    res_ch.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_MIN_PERIOD;
    cfg_data              = '0;
    src_idle_pct          = 0;
    min_period_now        = MIN_PERIOD_RST;
    for (int i = 0; i < NUM_CHANNELS; i++) wheel_capture[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: first edge measured from zero, glitch at and below the threshold,
    // first real update, a wrapped period and a stopped motor.
    send_capture(0, 32'd40, DIR_FWD, '0);
    send_capture(0, 32'd100, DIR_FWD, '1);
    send_capture(0, 32'd101, DIR_FWD, $urandom);
    send_capture(1, 32'hFFFF_FFFF, DIR_REV, '1);
    send_capture(1, 32'h0000_0501, DIR_STOP, '0);
    settle();

    // Largest numerators with a zero threshold: both velocity saturations, the alternate
    // reverse code, a zero period that is still a glitch, and travel wrapping below zero.
    configure('0, '1, '1, '1);
    send_capture(0, 32'd1, DIR_FWD, $urandom);
    send_capture(0, 32'd1, DIR_REV, $urandom);
    send_capture(0, 32'd1, DIR_REV_ALT, $urandom);
    send_capture(0, 32'd0, DIR_FWD, $urandom);
    send_capture(1, 32'd2, DIR_STOP, $urandom);
    settle();

    // Quotient exactly at the negative limit, then just past the positive one.
    configure('0, 32'h8000_0000, '0, 20'd1);
    send_capture(1, 32'd1, DIR_REV, $urandom);
    send_capture(1, 32'd1, DIR_FWD, $urandom);
    send_capture(1, 32'd2, DIR_FWD, $urandom);
    settle();

    // Largest threshold with zero velocity numerator.
    configure('1, '0, 32'h7FFF_FFFF, 20'h8_0000);
    send_capture(0, 32'h0000_FFFF, DIR_FWD, $urandom);
    send_capture(0, 32'h0001_0000, DIR_REV, $urandom);
    send_capture(0, 32'hFFFF_FFFF, DIR_REV_ALT, $urandom);
    send_capture(1, 32'h1234_5678, DIR_STOP, $urandom);
    settle();

    // Random traffic under several register settings and idling patterns.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(MIN_PERIOD_RST, VEL_NUMERATOR_RST, RPM_NUMERATOR_RST,
                     STEP_W'($urandom_range(0, 1000)));
        1: configure('0, $urandom, $urandom, '1);
        2: configure('1, '1, $urandom, STEP_W'($urandom_range(0, 20'hF_FFFF)));
        default: configure(MINP_W'($urandom_range(0, 16'hFFFF)), $urandom, $urandom,
                           STEP_W'($urandom_range(0, 20'hF_FFFF)));
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % MODE_SPAN == 0) begin
          case ((n / MODE_SPAN + phase) % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
            1: begin src_idle_pct = 52; sink_stall_pct <= 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct <= 52; end
            default: begin src_idle_pct = 19; sink_stall_pct <= 19; end
          endcase
        end
        // One long receiver hold-off while events keep coming.
        if (phase == 1 && n == 40) hold_requests <= hold_requests + 1;

        ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        pick = $urandom_range(0, 9);
        if (pick < 2) gap = $urandom_range(0, min_period_now);
        else if (pick == 2) gap = min_period_now + $urandom_range(0, 1);
        else if (pick == 3) gap = $urandom;
        else gap = min_period_now + 1 + $urandom_range(0, 200000);
        pick = $urandom_range(0, 9);
        if (pick < 5) dir = DIR_FWD;
        else if (pick < 7) dir = DIR_REV;
        else if (pick == 7) dir = DIR_REV_ALT;
        else dir = DIR_STOP;
        send_capture(ch, gap, dir, $urandom);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS encoder_period_speed_odometer_unit");
    end else begin
      $display("FAIL encoder_period_speed_odometer_unit");
    end
    $finish;
  end

endmodule
